[design/rainbow_cycle_pattern_macros.svh]
// assertion macros for the rainbow cycle pattern generator
`ifndef RAINBOW_CYCLE_PATTERN_MACROS_SVH
`define RAINBOW_CYCLE_PATTERN_MACROS_SVH

// same-cycle implication, checked out of reset
`define RCP_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcp implication violated");

// next-cycle implication, checked out of reset
`define RCP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcp next-cycle implication violated");

`endif

[design/rcp_pkg.sv]
// shared constants and types for the rainbow cycle pattern generator
package rcp_pkg;

  localparam int MAX_PIXELS  = 64;
  localparam int STEP_COUNT  = 255;
  localparam int DIV_STEPS   = 9;

  localparam logic [1:0] CFG_PIXEL_COUNT = 2'd0;
  localparam logic [1:0] CFG_BRIGHTNESS  = 2'd1;

  typedef struct packed {
    logic frame_start;
    logic div_step;
    logic div_first;
    logic pix_issue;
    logic step_adv;
  } rcp_cmd_t;

  typedef struct packed {
    logic adv;
    logic pix_last;
  } rcp_sts_t;

endpackage

[design/rcp_ifs.sv]
// handshake channel interfaces for the input, result and configuration words
interface rcp_in_if;
  logic valid;
  logic ready;
  logic frame_tick;
  modport source (output valid, output frame_tick, input ready);
  modport sink (input valid, input frame_tick, output ready);
endinterface

interface rcp_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_pixel;
  modport source (output valid, output pixel_index, output red, output green,
                  output blue, output last_pixel, input ready);
  modport sink (input valid, input pixel_index, input red, input green,
                input blue, input last_pixel, output ready);
endinterface

interface rcp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[design/rcp_ctrl.sv]
// frame sequencer: divider setup, pixel issue and step advance
module rcp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_tick,
  output logic              in_ready,
  input  rcp_pkg::rcp_sts_t sts,
  output rcp_pkg::rcp_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [3:0] div_cnt_r, div_cnt_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    div_cnt_nxt     = div_cnt_r;
    cmd             = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_tick) begin
          cmd.frame_start = 1'b1;
          div_cnt_nxt     = '0;
          state_nxt       = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (div_cnt_r == '0);
        div_cnt_nxt   = div_cnt_r + 4'd1;
        if (div_cnt_r == 4'(rcp_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.adv) begin
          cmd.pix_issue = 1'b1;
          if (sts.pix_last) begin
            cmd.step_adv = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

endmodule

[design/rcp_datapath.sv]
// config registers, 256/n divider, wheel position stepping and color pipeline
module rcp_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  rcp_pkg::rcp_cmd_t cmd,
  output rcp_pkg::rcp_sts_t sts,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [5:0]        out_pixel_index,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic              out_last
);

  logic [6:0] pix_count_r;
  logic [7:0] bright_r;
  logic [7:0] step_r;
  logic [6:0] n_eff;

  logic [6:0] rem_r;
  logic [8:0] quo_r;
  logic [7:0] div_sh;

  logic [5:0] idx_r;
  logic [8:0] ofs_r;
  logic [6:0] frac_r;
  logic [7:0] frac_sum;

  logic [7:0] pos, p, seg_q, tri_q, seg_lo;
  logic [7:0] wr, wg, wb;
  logic [8:0] step_inc;

  logic       s1_v_r, s2_v_r, s3_v_r;
  logic [5:0] s1_idx_r, s2_idx_r, s3_idx_r;
  logic       s1_last_r, s2_last_r, s3_last_r;
  logic [7:0] s1_r_r, s1_g_r, s1_b_r;
  logic [15:0] s2_r_r, s2_g_r, s2_b_r;
  logic [7:0] s3_r_r, s3_g_r, s3_b_r;
  logic       adv;

  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] y;
    y = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return y[15:8];
  endfunction

  // pixel count clamp
  always_comb begin
    if (pix_count_r == '0) begin
      n_eff = 7'd1;
    end else if (pix_count_r > 7'(rcp_pkg::MAX_PIXELS)) begin
      n_eff = 7'(rcp_pkg::MAX_PIXELS);
    end else begin
      n_eff = pix_count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_count_r <= 7'(rcp_pkg::MAX_PIXELS);
      bright_r    <= 8'd255;
    end else if (cfg_valid) begin
      if (cfg_index == rcp_pkg::CFG_PIXEL_COUNT) begin
        pix_count_r <= cfg_data[6:0];
      end else if (cfg_index == rcp_pkg::CFG_BRIGHTNESS) begin
        bright_r <= cfg_data;
      end
    end
  end

  // restoring division of 256 by n
  assign div_sh = {rem_r, cmd.div_first};

  always_ff @(posedge clk) begin
    if (cmd.frame_start) begin
      rem_r <= '0;
      quo_r <= '0;
    end else if (cmd.div_step) begin
      if (div_sh >= {1'b0, n_eff}) begin
        rem_r <= 7'(div_sh - {1'b0, n_eff});
        quo_r <= {quo_r[7:0], 1'b1};
      end else begin
        rem_r <= div_sh[6:0];
        quo_r <= {quo_r[7:0], 1'b0};
      end
    end
  end

  // per-pixel wheel offset, floor(i*256/n) kept as quotient plus remainder
  assign frac_sum = {1'b0, frac_r} + {1'b0, rem_r};

  always_ff @(posedge clk) begin
    if (cmd.frame_start) begin
      idx_r  <= '0;
      ofs_r  <= '0;
      frac_r <= '0;
    end else if (cmd.pix_issue) begin
      idx_r <= idx_r + 6'd1;
      if (frac_sum >= {1'b0, n_eff}) begin
        frac_r <= 7'(frac_sum - {1'b0, n_eff});
        ofs_r  <= ofs_r + quo_r + 9'd1;
      end else begin
        frac_r <= frac_sum[6:0];
        ofs_r  <= ofs_r + quo_r;
      end
    end
  end

  assign sts.pix_last = ({1'b0, idx_r} == (n_eff - 7'd1));

  assign step_inc = {1'b0, step_r} + 9'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.step_adv) begin
      step_r <= (step_inc >= 9'(rcp_pkg::STEP_COUNT)) ? 8'd0 : step_inc[7:0];
    end
  end

  // color wheel
  assign pos    = ofs_r[7:0] + step_r;
  assign p      = ~pos;
  assign seg_lo = (p < 8'd85) ? 8'd0 : (p < 8'd170) ? 8'd85 : 8'd170;
  assign seg_q  = p - seg_lo;
  assign tri_q  = {seg_q[6:0], 1'b0} + seg_q;

  always_comb begin
    if (p < 8'd85) begin
      wr = 8'd255 - tri_q;
      wg = 8'd0;
      wb = tri_q;
    end else if (p < 8'd170) begin
      wr = 8'd0;
      wg = tri_q;
      wb = 8'd255 - tri_q;
    end else begin
      wr = tri_q;
      wg = 8'd255 - tri_q;
      wb = 8'd0;
    end
  end

  // three-stage color pipeline, moves as a whole when the output is free
  assign adv       = !s3_v_r || out_ready;
  assign sts.adv   = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= cmd.pix_issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx_r  <= idx_r;
      s1_last_r <= sts.pix_last;
      s1_r_r    <= wr;
      s1_g_r    <= wg;
      s1_b_r    <= wb;
      s2_idx_r  <= s1_idx_r;
      s2_last_r <= s1_last_r;
      s2_r_r    <= 16'(s1_r_r) * 16'(bright_r);
      s2_g_r    <= 16'(s1_g_r) * 16'(bright_r);
      s2_b_r    <= 16'(s1_b_r) * 16'(bright_r);
      s3_idx_r  <= s2_idx_r;
      s3_last_r <= s2_last_r;
      s3_r_r    <= div255(s2_r_r);
      s3_g_r    <= div255(s2_g_r);
      s3_b_r    <= div255(s2_b_r);
    end
  end

  assign out_valid       = s3_v_r;
  assign out_pixel_index = s3_idx_r;
  assign out_red         = s3_r_r;
  assign out_green       = s3_g_r;
  assign out_blue        = s3_b_r;
  assign out_last        = s3_last_r;

endmodule

[design/rainbow_cycle_pattern.sv]
// top level of the rainbow cycle pattern generator
// Each accepted frame_tick word of 1 produces one result word per pixel, in pixel
// order, with the last pixel flagged; a tick of 0 is taken and produces nothing.
// A frame begins when the tick is taken; a setup follows in which an
// iterative restoring divider works out 256 / pixel_count one bit per cycle,
// then pixels are issued one per cycle while the color pipeline can advance
// (out_ready high or its last stage empty); each result passes, once its pixel
// is issued, through a three-stage color pipeline (wheel, brightness multiply,
// divide by 255). in_ready is high between frames: the next tick is taken in the
// cycle after the last pixel of a frame has been issued. Configuration writes
// are always taken.
module rainbow_cycle_pattern (
  input  logic       clk,
  input  logic       rst_n,
  rcp_in_if.sink     in_ch,
  rcp_out_if.source  out_ch,
  rcp_cfg_if.sink    cfg_ch
);

  `include "rainbow_cycle_pattern_macros.svh"

  rcp_pkg::rcp_cmd_t cmd;
  rcp_pkg::rcp_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  rcp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_tick  (in_ch.frame_tick),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rcp_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_pixel_index (out_ch.pixel_index),
    .out_red         (out_ch.red),
    .out_green       (out_ch.green),
    .out_blue        (out_ch.blue),
    .out_last        (out_ch.last_pixel)
  );

  `RCP_ASSERT_IMPLY(a_issue_needs_room, cmd.pix_issue, sts.adv)
  `RCP_ASSERT_IMPLY(a_step_on_last, cmd.step_adv, cmd.pix_issue && sts.pix_last)
  `RCP_ASSERT_IMPLY(a_no_issue_when_ready, in_ch.ready, !cmd.pix_issue && !cmd.div_step)
  `RCP_ASSERT_NEXT(a_frame_starts_div, cmd.frame_start, cmd.div_step && cmd.div_first)

endmodule
